/* rtl/saclu_pkg.sv */
// saclu_pkg: shared types, constants and helper functions of the cache tag lookup unit
// no dependencies; compiled before every other file of the block
package saclu_pkg;

    // fixed field widths
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int AGE_W     = 2;
    localparam int OFS_W     = 4;
    localparam int IDX_W     = 3;
    localparam int SET_OUT_W = 6;
    localparam int WAY_OUT_W = 2;
    localparam int CNT_W     = 32;
    localparam int LFSR_W    = 16;

    // apb port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes
    localparam logic [1:0] REG_OFFSET_BITS    = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS     = 2'd1;
    localparam logic [1:0] REG_REPLACE_POLICY = 2'd2;

    // register limits and reset values
    localparam logic [OFS_W-1:0] OFS_MAX   = 4'd12;
    localparam logic [OFS_W-1:0] OFS_RESET = 4'd2;
    localparam logic [IDX_W-1:0] IDX_MAX   = 3'd6;
    localparam logic [IDX_W-1:0] IDX_RESET = 3'd6;

    // replacement policy codes
    localparam logic POLICY_RANDOM = 1'b0;
    localparam logic POLICY_LRU    = 1'b1;

    // ages
    localparam logic [AGE_W-1:0] AGE_MAX = 2'd3;

    // victim lfsr
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // reciprocal shift for the way modulo, exact for 16-bit values and up to 16 ways
    localparam int RECIP_SHIFT = 20;

    typedef struct packed {
        logic [OFS_W-1:0] offset_bits;
        logic [IDX_W-1:0] index_bits;
        logic             replace_policy;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic             valid;
        logic [AGE_W-1:0] age;
    } way_state_t;

    // galois lfsr, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] shifted;
        shifted = s >> 1;
        return s[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

endpackage

/* rtl/saclu_if.sv */
// saclu_in_if / saclu_out_if: valid/ready channels of the cache tag lookup unit
// depends on saclu_pkg for the payload widths
interface saclu_in_if;
    logic                           valid;
    logic                           ready;
    logic [saclu_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface saclu_out_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [saclu_pkg::WAY_OUT_W-1:0]  way_used;
    logic [saclu_pkg::SET_OUT_W-1:0]  set_used;
    logic [saclu_pkg::CNT_W-1:0]      hit_total;
    logic [saclu_pkg::CNT_W-1:0]      miss_total;

    modport source (output valid, output hit, output way_used, output set_used,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input way_used, input set_used,
                    input hit_total, input miss_total, output ready);
endinterface

/* rtl/saclu_regs.sv */
// saclu_regs: apb configuration registers of the cache tag lookup unit
// depends on saclu_pkg
module saclu_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [saclu_pkg::PADDR_W-1:0]     paddr,
    input  logic [saclu_pkg::PDATA_W-1:0]     pwdata,
    output logic [saclu_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    output saclu_pkg::cfg_t                   cfg
);

    saclu_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [1:0]      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits    <= saclu_pkg::OFS_RESET;
            cfg_reg.index_bits     <= saclu_pkg::IDX_RESET;
            cfg_reg.replace_policy <= saclu_pkg::POLICY_LRU;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                saclu_pkg::REG_OFFSET_BITS:
                    cfg_reg.offset_bits <= pwdata[saclu_pkg::OFS_W-1:0];
                saclu_pkg::REG_INDEX_BITS:
                    cfg_reg.index_bits <= pwdata[saclu_pkg::IDX_W-1:0];
                saclu_pkg::REG_REPLACE_POLICY:
                    cfg_reg.replace_policy <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            saclu_pkg::REG_OFFSET_BITS:
                prdata = {{(saclu_pkg::PDATA_W-saclu_pkg::OFS_W){1'b0}}, cfg_reg.offset_bits};
            saclu_pkg::REG_INDEX_BITS:
                prdata = {{(saclu_pkg::PDATA_W-saclu_pkg::IDX_W){1'b0}}, cfg_reg.index_bits};
            saclu_pkg::REG_REPLACE_POLICY:
                prdata = {{(saclu_pkg::PDATA_W-1){1'b0}}, cfg_reg.replace_policy};
            default:
                prdata = '0;
        endcase
    end

endmodule

/* rtl/saclu_ctrl.sv */
// saclu_ctrl: controller state machine of the cache tag lookup unit
// depends on saclu_pkg for the command and status structs
module saclu_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  saclu_pkg::sts_t   sts,
    output saclu_pkg::cmd_t   cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/saclu_dp.sv */
// saclu_dp: datapath of the cache tag lookup unit: address split, tag and state
// memories, way compare, victim choice, counters and output register; uses saclu_pkg
module saclu_dp #(
    parameter int WAYS      = 4,
    parameter int MAX_SETS  = 64,
    parameter int ADDR_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  saclu_pkg::cfg_t                     cfg,
    input  saclu_pkg::cmd_t                     cmd,
    output saclu_pkg::sts_t                     sts,
    input  logic [saclu_pkg::ADDR_W-1:0]        address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [saclu_pkg::WAY_OUT_W-1:0]     way_used,
    output logic [saclu_pkg::SET_OUT_W-1:0]     set_used,
    output logic [saclu_pkg::CNT_W-1:0]         hit_total,
    output logic [saclu_pkg::CNT_W-1:0]         miss_total
);

    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int TAB_N   = 2 ** saclu_pkg::SET_OUT_W;
    localparam int PROD_W  = saclu_pkg::LFSR_W + saclu_pkg::RECIP_SHIFT + 1;
    localparam logic [saclu_pkg::ADDR_W-1:0] ADDR_MASK =
        saclu_pkg::ADDR_W'((65'd1 << ADDR_BITS) - 65'd1);
    localparam logic [saclu_pkg::RECIP_SHIFT:0] RECIP =
        (saclu_pkg::RECIP_SHIFT+1)'(((2 ** saclu_pkg::RECIP_SHIFT) + WAYS - 1) / WAYS);

    // address split
    logic [saclu_pkg::ADDR_W-1:0]     addr_m;
    logic [saclu_pkg::ADDR_W-1:0]     blk;
    logic [saclu_pkg::TAG_W-1:0]      tag_in;
    logic [saclu_pkg::OFS_W-1:0]      ob;
    logic [saclu_pkg::IDX_W-1:0]      ib;
    logic [saclu_pkg::SET_OUT_W-1:0]  idx_mask;
    logic [saclu_pkg::SET_OUT_W-1:0]  set_raw;
    logic [SET_W-1:0]                 set_in;
    logic [SET_W-1:0]                 set_tab [TAB_N];

    // memories and lookup registers
    logic [WAYS-1:0][saclu_pkg::TAG_W-1:0]  tag_mem [MAX_SETS];
    saclu_pkg::way_state_t [WAYS-1:0]       state_mem [MAX_SETS];
    logic [WAYS-1:0][saclu_pkg::TAG_W-1:0]  tag_rd_reg;
    saclu_pkg::way_state_t [WAYS-1:0]       st_rd_reg;
    logic [saclu_pkg::TAG_W-1:0]            tag_reg;
    logic [SET_W-1:0]                       set_reg;
    logic [SET_W-1:0]                       clr_cnt_reg;

    // compare and update
    logic [WAYS-1:0]                        match;
    logic [WAYS-1:0]                        age_max_hit;
    logic [WAYS-1:0]                        age_lvl2;
    logic [WAYS-1:0]                        age_lvl1;
    logic                                   hit_now;
    logic                                   set_full;
    logic [WAY_W-1:0]                       hit_way;
    logic [WAY_W-1:0]                       inv_way;
    logic [WAY_W-1:0]                       lru_way;
    logic [WAY_W-1:0]                       rnd_way;
    logic [WAY_W-1:0]                       way_sel;
    logic [saclu_pkg::AGE_W-1:0]            lru_target;
    logic [saclu_pkg::AGE_W:0]              old_age;
    saclu_pkg::way_state_t [WAYS-1:0]       st_wr;
    logic [WAYS-1:0][saclu_pkg::TAG_W-1:0]  tag_wr_row;
    logic                                   lfsr_step;

    // victim lfsr and its residue pipeline
    logic [saclu_pkg::LFSR_W-1:0]           lfsr_reg;
    logic [saclu_pkg::LFSR_W-1:0]           nx_reg;
    logic [PROD_W-1:0]                      prod_reg;
    logic [PROD_W-saclu_pkg::RECIP_SHIFT-1:0] quot;
    logic [saclu_pkg::LFSR_W-1:0]           rnd_diff;

    // counters and output register
    logic [saclu_pkg::CNT_W-1:0]            hit_cnt_reg;
    logic [saclu_pkg::CNT_W-1:0]            miss_cnt_reg;
    logic [saclu_pkg::CNT_W-1:0]            hit_cnt_next;
    logic [saclu_pkg::CNT_W-1:0]            miss_cnt_next;
    logic                                   out_valid_reg;
    logic                                   out_hit_reg;
    logic [saclu_pkg::WAY_OUT_W-1:0]        out_way_reg;
    logic [saclu_pkg::SET_OUT_W-1:0]        out_set_reg;

    // set index folded into the store depth
    for (genvar i = 0; i < TAB_N; i++)
    begin : g_set_tab
        assign set_tab[i] = SET_W'(i % MAX_SETS);
    end

    // split the incoming address into tag and set
    always_comb
    begin
        addr_m   = address & ADDR_MASK;
        ob       = (cfg.offset_bits > saclu_pkg::OFS_MAX) ? saclu_pkg::OFS_MAX
                                                          : cfg.offset_bits;
        ib       = (cfg.index_bits > saclu_pkg::IDX_MAX) ? saclu_pkg::IDX_MAX
                                                         : cfg.index_bits;
        blk      = addr_m >> ob;
        idx_mask = saclu_pkg::SET_OUT_W'((7'd1 << ib) - 7'd1);
        set_raw  = blk[saclu_pkg::SET_OUT_W-1:0] & idx_mask;
        tag_in   = blk >> ib;
        set_in   = set_tab[set_raw];
    end

    // latch the access on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg <= tag_in;
            set_reg <= set_in;
        end
    end

    // tag memory, never cleared
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_rd_reg <= tag_mem[set_in];
        end
        if (cmd.commit && !hit_now)
        begin
            tag_mem[set_reg] <= tag_wr_row;
        end
    end

    // valid and age memory, cleared row by row after reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_rd_reg <= state_mem[set_in];
        end
        if (cmd.commit)
        begin
            state_mem[set_reg] <= st_wr;
        end
        else if (cmd.clear)
        begin
            state_mem[clr_cnt_reg] <= '0;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    // way compare and victim choice
    always_comb
    begin
        match       = '0;
        age_max_hit = '0;
        age_lvl2    = '0;
        age_lvl1    = '0;
        set_full    = 1'b1;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w]       = st_rd_reg[w].valid && (tag_rd_reg[w] == tag_reg);
            age_max_hit[w] = (st_rd_reg[w].age == saclu_pkg::AGE_MAX);
            age_lvl2[w]    = (st_rd_reg[w].age == 2'd2);
            age_lvl1[w]    = (st_rd_reg[w].age == 2'd1);
            set_full       = set_full & st_rd_reg[w].valid;
        end
        hit_now = |match;

        // greatest age present in the set
        if (|age_max_hit)
        begin
            lru_target = saclu_pkg::AGE_MAX;
        end
        else if (|age_lvl2)
        begin
            lru_target = 2'd2;
        end
        else if (|age_lvl1)
        begin
            lru_target = 2'd1;
        end
        else
        begin
            lru_target = 2'd0;
        end

        // lowest way of each kind
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!st_rd_reg[w].valid)
            begin
                inv_way = WAY_W'(w);
            end
            if (st_rd_reg[w].age == lru_target)
            begin
                lru_way = WAY_W'(w);
            end
        end

        // lfsr residue from the registered reciprocal product
        quot     = prod_reg[PROD_W-1:saclu_pkg::RECIP_SHIFT];
        rnd_diff = nx_reg - saclu_pkg::LFSR_W'(quot * (PROD_W-saclu_pkg::RECIP_SHIFT)'(WAYS));
        rnd_way  = WAY_W'(rnd_diff);

        if (hit_now)
        begin
            way_sel = hit_way;
        end
        else if (!set_full)
        begin
            way_sel = inv_way;
        end
        else if (cfg.replace_policy == saclu_pkg::POLICY_LRU)
        begin
            way_sel = lru_way;
        end
        else
        begin
            way_sel = rnd_way;
        end

        lfsr_step = !hit_now && set_full && (cfg.replace_policy == saclu_pkg::POLICY_RANDOM);

        // a freshly filled way counts as older than any age
        if (!hit_now && !set_full)
        begin
            old_age = {1'b1, {saclu_pkg::AGE_W{1'b0}}};
        end
        else
        begin
            old_age = {1'b0, st_rd_reg[way_sel].age};
        end

        // age update
        for (int w = 0; w < WAYS; w++)
        begin
            st_wr[w] = st_rd_reg[w];
            if (WAY_W'(w) == way_sel)
            begin
                st_wr[w].valid = 1'b1;
                st_wr[w].age   = '0;
            end
            else if (st_rd_reg[w].valid && ({1'b0, st_rd_reg[w].age} < old_age)
                     && (st_rd_reg[w].age != saclu_pkg::AGE_MAX))
            begin
                st_wr[w].age = st_rd_reg[w].age + 2'd1;
            end
        end

        tag_wr_row          = tag_rd_reg;
        tag_wr_row[way_sel] = tag_reg;
    end

    // lfsr state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= saclu_pkg::LFSR_SEED;
        end
        else if (cmd.commit && lfsr_step)
        begin
            lfsr_reg <= nx_reg;
        end
    end

    // next lfsr value and its reciprocal product, registered from the state
    always_ff @(posedge clk)
    begin
        nx_reg   <= saclu_pkg::lfsr_next(lfsr_reg);
        prod_reg <= PROD_W'(saclu_pkg::lfsr_next(lfsr_reg)) * PROD_W'(RECIP);
    end

    // saturating counters
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (hit_now)
        begin
            if (hit_cnt_reg != '1)
            begin
                hit_cnt_next = hit_cnt_reg + 32'd1;
            end
        end
        else if (miss_cnt_reg != '1)
        begin
            miss_cnt_next = miss_cnt_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg <= hit_now;
            out_way_reg <= saclu_pkg::WAY_OUT_W'(way_sel);
            out_set_reg <= saclu_pkg::SET_OUT_W'(set_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = out_hit_reg;
    assign way_used       = out_way_reg;
    assign set_used       = out_set_reg;
    assign hit_total      = hit_cnt_reg;
    assign miss_total     = miss_cnt_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.clear_last = (clr_cnt_reg == SET_W'(MAX_SETS - 1));

endmodule

/* rtl/set_assoc_cache_tag_lookup_unit.sv */
// set_assoc_cache_tag_lookup_unit: top level of the set-associative cache tag store
// depends on saclu_pkg, saclu_in_if, saclu_out_if, saclu_regs, saclu_ctrl, saclu_dp
//
// Usage:
// - in_ch carries one access address per transfer; out_ch returns one result per
//   access: hit flag, way hit or filled, set index and the running hit/miss totals.
// - Configuration goes through the apb port: offset_bits at 0x0, index_bits at 0x4,
//   replace_policy at 0x8 (1 lru, 0 lfsr). Write it only while the unit is idle.
// - Each access reads the set row from the tag and state memories in its transfer
//   cycle; in the compare step that follows, all ways are compared, the victim is
//   picked and the row is written back over the same single memory port, and the
//   result is registered. No new access is taken until that write-back is done.
// - A result waits in the output register while out_ch.ready is low; one more
//   access can be taken meanwhile and then holds in its compare step until the
//   output register frees up.
// - After reset the valid/age memory is cleared one set per cycle, all MAX_SETS sets,
//   during which in_ch.ready stays low. Counters reset to zero, lfsr to 0xACE1.
module set_assoc_cache_tag_lookup_unit #(
    parameter int WAYS      = 4,
    parameter int MAX_SETS  = 64,
    parameter int ADDR_BITS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    saclu_in_if.sink                          in_ch,
    saclu_out_if.source                       out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [saclu_pkg::PADDR_W-1:0]     paddr,
    input  logic [saclu_pkg::PDATA_W-1:0]     pwdata,
    output logic [saclu_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    saclu_pkg::cfg_t cfg;
    saclu_pkg::cmd_t cmd;
    saclu_pkg::sts_t sts;
    logic            in_ready;

    assign in_ch.ready = in_ready;

    // configuration registers
    saclu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencing
    saclu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // lookup datapath
    saclu_dp #(
        .WAYS      (WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts),
        .address    (in_ch.address),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .hit        (out_ch.hit),
        .way_used   (out_ch.way_used),
        .set_used   (out_ch.set_used),
        .hit_total  (out_ch.hit_total),
        .miss_total (out_ch.miss_total)
    );

endmodule

/* verif/tag_lookup_checker.sv */
// tag_lookup_checker: predicts every lookup of the cache tag unit and compares its results
// depends on saclu_pkg, saclu_in_if and saclu_out_if; follows register writes on the apb port
`timescale 1ns / 1ps

module tag_lookup_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    saclu_in_if                                in_mon,
    saclu_out_if                               out_mon,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [saclu_pkg::PADDR_W-1:0]      paddr,
    input  logic [saclu_pkg::PDATA_W-1:0]      pwdata,
    output int                                 errors,
    output int                                 pending
);

    localparam int WAYS_N       = 4;
    localparam int SETS_N       = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                            hit;
        logic [saclu_pkg::WAY_OUT_W-1:0] way_used;
        logic [saclu_pkg::SET_OUT_W-1:0] set_used;
        logic [saclu_pkg::CNT_W-1:0]     hit_total;
        logic [saclu_pkg::CNT_W-1:0]     miss_total;
    } lookup_result_t;

    // shadow copy of the tag store and its bookkeeping
    logic [saclu_pkg::TAG_W-1:0]  line_tag   [SETS_N*WAYS_N];
    logic                         line_valid [SETS_N*WAYS_N];
    logic [saclu_pkg::AGE_W-1:0]  line_age   [SETS_N*WAYS_N];
    logic [saclu_pkg::LFSR_W-1:0] victim_seq;
    logic [saclu_pkg::CNT_W-1:0]  hit_count;
    logic [saclu_pkg::CNT_W-1:0]  miss_count;
    saclu_pkg::cfg_t              cfg_shadow;

    lookup_result_t    pending_lookups [$];
    int                err_count;

    // ways younger than the touched one grow one step older, the touched way becomes newest
    function automatic void refresh_ages(input int unsigned first, input int unsigned way,
                                         input int unsigned old_age);
        for (int unsigned w = 0; w < WAYS_N; w++)
        begin
            if (w != way && line_valid[first + w] && line_age[first + w] < old_age
                && line_age[first + w] < saclu_pkg::AGE_MAX)
            begin
                line_age[first + w] = line_age[first + w] + 1'b1;
            end
        end
        line_age[first + way] = '0;
    endfunction

    // one access against the shadow store; updates it and returns the expected result
    function automatic lookup_result_t predict_lookup(
        input logic [saclu_pkg::ADDR_W-1:0] address);
        int unsigned                  ob;
        int unsigned                  ib;
        int unsigned                  set_idx;
        int unsigned                  first;
        int unsigned                  way;
        int unsigned                  best;
        logic [saclu_pkg::ADDR_W-1:0] blk;
        logic [saclu_pkg::TAG_W-1:0]  tag;
        logic                         hit;
        logic                         placed;
        lookup_result_t               r;

        ob      = (cfg_shadow.offset_bits > saclu_pkg::OFS_MAX) ? saclu_pkg::OFS_MAX
                                                                : cfg_shadow.offset_bits;
        ib      = (cfg_shadow.index_bits > saclu_pkg::IDX_MAX) ? saclu_pkg::IDX_MAX
                                                               : cfg_shadow.index_bits;
        blk     = address >> ob;
        set_idx = (blk & ((32'd1 << ib) - 32'd1)) % SETS_N;
        tag     = blk >> ib;
        first   = set_idx * WAYS_N;
        hit     = 1'b0;
        placed  = 1'b0;
        way     = 0;

        // parallel tag compare, lowest matching way
        for (int unsigned w = 0; w < WAYS_N; w++)
        begin
            if (!hit && line_valid[first + w] && line_tag[first + w] == tag)
            begin
                hit = 1'b1;
                way = w;
            end
        end

        if (hit)
        begin
            refresh_ages(first, way, line_age[first + way]);
            if (hit_count != '1)
                hit_count++;
        end
        else
        begin
            if (miss_count != '1)
                miss_count++;
            // first invalid way takes the fill and counts as oldest
            for (int unsigned w = 0; w < WAYS_N; w++)
            begin
                if (!placed && !line_valid[first + w])
                begin
                    placed = 1'b1;
                    way    = w;
                end
            end
            if (placed)
            begin
                refresh_ages(first, way, saclu_pkg::AGE_MAX + 1);
            end
            else
            begin
                if (cfg_shadow.replace_policy == saclu_pkg::POLICY_LRU)
                begin
                    // oldest way, lowest number on a tie
                    best = 0;
                    for (int unsigned w = 0; w < WAYS_N; w++)
                    begin
                        if (line_age[first + w] > best)
                        begin
                            best = line_age[first + w];
                            way  = w;
                        end
                    end
                end
                else
                begin
                    victim_seq = victim_seq[0] ? ((victim_seq >> 1) ^ saclu_pkg::LFSR_TAPS)
                                               : (victim_seq >> 1);
                    way = victim_seq % WAYS_N;
                end
                refresh_ages(first, way, line_age[first + way]);
            end
            line_tag[first + way]   = tag;
            line_valid[first + way] = 1'b1;
        end

        r.hit        = hit;
        r.way_used   = way[saclu_pkg::WAY_OUT_W-1:0];
        r.set_used   = set_idx[saclu_pkg::SET_OUT_W-1:0];
        r.hit_total  = hit_count;
        r.miss_total = miss_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t got;
        lookup_result_t want;
        lookup_result_t pred;

        if (!rst_n)
        begin
            for (int i = 0; i < SETS_N * WAYS_N; i++)
            begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_age[i]   = '0;
            end
            victim_seq                = saclu_pkg::LFSR_SEED;
            hit_count                 = '0;
            miss_count                = '0;
            cfg_shadow.offset_bits    = saclu_pkg::OFS_RESET;
            cfg_shadow.index_bits     = saclu_pkg::IDX_RESET;
            cfg_shadow.replace_policy = saclu_pkg::POLICY_LRU;
            pending_lookups.delete();
            err_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // register writes; unknown indexes are ignored
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[saclu_pkg::PADDR_W-1:2])
                    saclu_pkg::REG_OFFSET_BITS:
                        cfg_shadow.offset_bits    = pwdata[saclu_pkg::OFS_W-1:0];
                    saclu_pkg::REG_INDEX_BITS:
                        cfg_shadow.index_bits     = pwdata[saclu_pkg::IDX_W-1:0];
                    saclu_pkg::REG_REPLACE_POLICY:
                        cfg_shadow.replace_policy = pwdata[0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expectation
            if (out_mon.valid && out_mon.ready)
            begin
                got.hit        = out_mon.hit;
                got.way_used   = out_mon.way_used;
                got.set_used   = out_mon.set_used;
                got.hit_total  = out_mon.hit_total;
                got.miss_total = out_mon.miss_total;
                if (pending_lookups.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                    begin
                        $display("%0t tag_lookup_checker: result with no access pending",
                                 $realtime);
                        $display("    actual   hit %0b way %0d set %0d hits %0d misses %0d",
                                 got.hit, got.way_used, got.set_used,
                                 got.hit_total, got.miss_total);
                    end
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (got.hit !== want.hit || got.way_used !== want.way_used
                        || got.set_used !== want.set_used || got.hit_total !== want.hit_total
                        || got.miss_total !== want.miss_total)
                    begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT)
                        begin
                            $display("%0t tag_lookup_checker: mismatch", $realtime);
                            $display("    expected hit %0b way %0d set %0d hits %0d misses %0d",
                                     want.hit, want.way_used, want.set_used,
                                     want.hit_total, want.miss_total);
                            $display("    actual   hit %0b way %0d set %0d hits %0d misses %0d",
                                     got.hit, got.way_used, got.set_used,
                                     got.hit_total, got.miss_total);
                        end
                    end
                end
            end

            // address transfer
            if (in_mon.valid && in_mon.ready)
            begin
                pred            = predict_lookup(in_mon.address);
                pending_lookups = {pending_lookups, pred};
            end

            errors  <= err_count;
            pending <= pending_lookups.size();
        end
    end

endmodule

/* verif/set_assoc_cache_tag_lookup_unit_tb.sv */
// set_assoc_cache_tag_lookup_unit_tb: stimulus, register setup and verdict for the tag lookup unit
// depends on saclu_pkg, saclu_in_if, saclu_out_if, the unit itself and tag_lookup_checker
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_unit_tb;

    localparam int HOLD_CYCLES  = 150;
    // longest quiet stretch: the long hold plus a stall and a gap, with wide margin
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int CLEAR_WAIT   = 128;
    localparam int PHASE_ITEMS  = 225;
    localparam logic [saclu_pkg::PADDR_W-1:0] UNUSED_REG_ADDR = 4'hC;

    localparam logic [saclu_pkg::ADDR_W-1:0] SINGLE_SET_SEQ [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
        32'h0000_0002, 32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0002
    };

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [saclu_pkg::PADDR_W-1:0] paddr;
    logic [saclu_pkg::PDATA_W-1:0] pwdata;
    logic [saclu_pkg::PDATA_W-1:0] prdata;
    logic                          pready;
    int                            errors;
    int                            pending;
    int                            idle_cycles = 0;
    bit                            src_gaps;
    bit                            sink_stalls;
    bit                            hold_req;
    bit                            hold_served;

    saclu_in_if  in_ch ();
    saclu_out_if out_ch ();

    set_assoc_cache_tag_lookup_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tag_lookup_checker u_lookup_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (errors),
        .pending (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [saclu_pkg::PADDR_W-1:0] reg_addr(input logic [1:0] idx);
        return {idx, 2'b00};
    endfunction

    // setup and access cycle of one register write
    task automatic apb_write(input logic [saclu_pkg::PADDR_W-1:0] a,
                             input logic [saclu_pkg::PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all three registers, with junk in the unused upper data bits
    task automatic configure(input logic [saclu_pkg::OFS_W-1:0] ofs,
                             input logic [saclu_pkg::IDX_W-1:0] idx,
                             input logic pol);
        logic [saclu_pkg::PDATA_W-1:0] noise;
        noise = $urandom();
        apb_write(reg_addr(saclu_pkg::REG_OFFSET_BITS),
                  {noise[saclu_pkg::PDATA_W-1:saclu_pkg::OFS_W], ofs});
        noise = $urandom();
        apb_write(reg_addr(saclu_pkg::REG_INDEX_BITS),
                  {noise[saclu_pkg::PDATA_W-1:saclu_pkg::IDX_W], idx});
        noise = $urandom();
        apb_write(reg_addr(saclu_pkg::REG_REPLACE_POLICY),
                  {noise[saclu_pkg::PDATA_W-1:1], pol});
        apb_release();
    endtask

    // stop offering and wait until every lookup has returned
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // one address transfer, with an optional gap ahead of it
    task automatic send_access(input logic [saclu_pkg::ADDR_W-1:0] a);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.address <= a;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // accesses crowded onto one to three sets with two to eight tags, often more than ways, plus stray addresses
    task automatic random_traffic(input logic [saclu_pkg::OFS_W-1:0] ofs,
                                  input logic [saclu_pkg::IDX_W-1:0] idx,
                                  input int n_items);
        logic [saclu_pkg::ADDR_W-1:0] tag_pool [8];
        logic [saclu_pkg::ADDR_W-1:0] set_pool [3];
        logic [saclu_pkg::ADDR_W-1:0] a;
        int                           ob;
        int                           ib;
        int                           n_tags;
        int                           n_sets;

        ob     = (ofs > saclu_pkg::OFS_MAX) ? saclu_pkg::OFS_MAX : ofs;
        ib     = (idx > saclu_pkg::IDX_MAX) ? saclu_pkg::IDX_MAX : idx;
        n_tags = 2;
        n_sets = 1;
        for (int i = 0; i < n_items; i++)
        begin
            // fresh working set now and then
            if (i % 60 == 0)
            begin
                n_tags = $urandom_range(2, 8);
                n_sets = $urandom_range(1, 3);
                foreach (tag_pool[k])
                    tag_pool[k] = $urandom();
                foreach (set_pool[k])
                    set_pool[k] = $urandom_range(0, (1 << ib) - 1);
            end
            if ($urandom_range(0, 99) < 15)
                a = $urandom();
            else
                a = (tag_pool[$urandom_range(0, n_tags - 1)] << (ob + ib))
                    | (set_pool[$urandom_range(0, n_sets - 1)] << ob)
                    | ($urandom() & ((32'd1 << ob) - 32'd1));
            send_access(a);
        end
    endtask

    task automatic run_phase(input logic [saclu_pkg::OFS_W-1:0] ofs,
                             input logic [saclu_pkg::IDX_W-1:0] idx,
                             input logic pol, input bit with_hold);
        wait_idle();
        configure(ofs, idx, pol);
        if (with_hold)
            hold_req = 1'b1;
        random_traffic(ofs, idx, PHASE_ITEMS);
    endtask

    // result side: random stalls, and one long hold so the unit backs up
    initial
    begin
        out_ch.ready = 1'b0;
        hold_served  = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("set_assoc_cache_tag_lookup_unit_tb: errors");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.address = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // the unit clears its valid and age rows before taking accesses
        for (int i = 0; i < CLEAR_WAIT && !in_ch.ready; i++)
            @(posedge clk);

        // one set, address is the tag: fills, hits, then an lru eviction
        configure(4'd0, 3'd0, saclu_pkg::POLICY_LRU);
        foreach (SINGLE_SET_SEQ[i])
            send_access(SINGLE_SET_SEQ[i]);

        // out-of-range settings act as 12 and 6; six tags into one set under random victims
        wait_idle();
        configure(4'd15, 3'd7, saclu_pkg::POLICY_RANDOM);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0FFF);
        for (int t = 1; t <= 6; t++)
            send_access((32'(t) << 18) | (32'd5 << 12));
        send_access(32'hFFFF_FFFF);

        // write to an unknown register index must leave the settings alone
        wait_idle();
        apb_write(UNUSED_REG_ADDR, 32'hFFFF_FFFF);
        apb_release();
        send_access(32'h0004_5123);
        send_access(32'h0000_0000);

        // random phases over several settings, extremes included
        run_phase(4'd2,  3'd6, saclu_pkg::POLICY_LRU,    1'b0);
        run_phase(4'd0,  3'd0, saclu_pkg::POLICY_RANDOM, 1'b0);
        run_phase(4'd12, 3'd6, saclu_pkg::POLICY_RANDOM, 1'b0);
        run_phase(4'd5,  3'd3, saclu_pkg::POLICY_LRU,    1'b1);
        run_phase(4'd13, 3'd7, saclu_pkg::POLICY_LRU,    1'b0);
        run_phase(4'd1,  3'd2, saclu_pkg::POLICY_RANDOM, 1'b0);
        run_phase(4'd7,  3'd4, saclu_pkg::POLICY_LRU,    1'b0);

        // closing stretch at full rate
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        run_phase(4'd3,  3'd1, saclu_pkg::POLICY_RANDOM, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("set_assoc_cache_tag_lookup_unit_tb: clean");
        else
            $display("set_assoc_cache_tag_lookup_unit_tb: errors");
        $finish;
    end

endmodule
